// File: hw/rtl/mthe_pkg.sv
// mthe_pkg: shared constants, types and helpers of the tree hash encoder
// used by the channel interfaces, the lanes, the merge stage and the top level
`default_nettype none

package mthe_pkg;

  // block configuration
  localparam int unsigned NUM_CODEBOOKS   = 16;
  localparam int unsigned TREE_DEPTH      = 4;

  // field widths
  localparam int unsigned FUNC_W          = 2;
  localparam int unsigned CB_W            = 4;
  localparam int unsigned LEVEL_W         = 2;
  localparam int unsigned NODE_W          = 4;
  localparam int unsigned VAL_W           = 16;
  localparam int unsigned BUCKET_W        = 4;
  localparam int unsigned THR_W           = 8;
  localparam int unsigned ACC_W           = 2 * VAL_W;

  localparam int unsigned NODES_PER_LEVEL = 1 << NODE_W;

  // rows actually addressable by the 4-bit codebook field
  localparam int unsigned CB_SLOTS = (NUM_CODEBOOKS < (1 << CB_W)) ? NUM_CODEBOOKS
                                                                   : (1 << CB_W);
  localparam int unsigned CB_AW    = (CB_SLOTS > 1) ? $clog2(CB_SLOTS) : 1;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD_THR    = 2'd0,
    FUNC_LOAD_SCALE  = 2'd1,
    FUNC_LOAD_OFFSET = 2'd2,
    FUNC_ENCODE      = 2'd3
  } func_e_t;

  typedef logic signed [THR_W-1:0]           thr_t;
  typedef thr_t [NODES_PER_LEVEL-1:0]        thr_row_t;
  typedef logic [NODES_PER_LEVEL-1:0]        cmp_vec_t;
  typedef cmp_vec_t [TREE_DEPTH-1:0]         cmp_arr_t;

  // table write broadcast to every lane
  typedef struct packed {
    logic                    wr;
    func_e_t                 func;
    logic [CB_AW-1:0]        addr;
    logic [LEVEL_W-1:0]      level;
    logic [NODE_W-1:0]       node;
    logic signed [VAL_W-1:0] value;
  } load_cmd_t;

  // pipeline advance strobes shared by the lanes
  typedef struct packed {
    logic rd;
    logic mul;
    logic cmp;
  } stage_en_t;

  function automatic logic cb_in_range(input logic [CB_W-1:0] cb);
    return {{(32-CB_W){1'b0}}, cb} < 32'(NUM_CODEBOOKS);
  endfunction

  // saturate to the signed 8-bit range
  function automatic thr_t sat8(input logic signed [VAL_W:0] v);
    thr_t res;
    if (v > 17'sd127) begin
      res = 8'sd127;
    end else if (v < 17'sh1ff80) begin
      res = 8'sh80;
    end else begin
      res = v[THR_W-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/mthe_if.sv
// mthe_if: valid/ready channel interfaces of the tree hash encoder
// depends on mthe_pkg for field widths
`default_nettype none

interface mthe_in_if import mthe_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [FUNC_W-1:0]       func;
  logic [CB_W-1:0]         codebook;
  logic [LEVEL_W-1:0]      level;
  logic [NODE_W-1:0]       node;
  logic signed [VAL_W-1:0] load_value;
  logic signed [VAL_W-1:0] value_l0;
  logic signed [VAL_W-1:0] value_l1;
  logic signed [VAL_W-1:0] value_l2;
  logic signed [VAL_W-1:0] value_l3;

  modport source (output valid, func, codebook, level, node, load_value,
                  value_l0, value_l1, value_l2, value_l3, input ready);
  modport sink   (input valid, func, codebook, level, node, load_value,
                  value_l0, value_l1, value_l2, value_l3, output ready);
endinterface

interface mthe_out_if import mthe_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CB_W-1:0]     code_codebook;
  logic [BUCKET_W-1:0] bucket_code;

  modport source (output valid, code_codebook, bucket_code, input ready);
  modport sink   (input valid, code_codebook, bucket_code, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/maddness_tree_hash_encoder_top.sv
// maddness_tree_hash_encoder_top: balanced-tree hash encoder, one lane per level
// depends on mthe_pkg, mthe_if, mthe_lane and mthe_merge
//
//   channel    dir   handshake            word
//   in_word    in    valid / ready        func, codebook, level, node, load_value,
//                                         value_l0 .. value_l3
//   out_word   out   valid / ready        code_codebook, bucket_code
//
// one word accepted per cycle while out_word is not stalled; an encode word shows up on
// out_word after the table read register at the accepting edge, the multiply-add, the
// round/compare and the tree walk + output reg
// table loads write at the accepting edge and are seen by an encode word on the next one
// rst_n clears only the stage valid bits; the tables are undefined until loaded
// a stalled out_word backs up stage by stage, empty stages keep taking words
`default_nettype none

module maddness_tree_hash_encoder_top import mthe_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  mthe_in_if.sink    in_word,
  mthe_out_if.source out_word
);

  // stage valids and codebook tags
  logic            v_a_r, v_b_r, v_c_r;
  logic            v_a_nxt, v_b_nxt, v_c_nxt;
  logic [CB_W-1:0] cb_a_r, cb_b_r, cb_c_r;

  logic            rdy_a, rdy_b, rdy_c;
  logic            accept;
  logic            cb_ok;
  logic            acc_enc;

  load_cmd_t       ld;
  stage_en_t       en;
  cmp_arr_t        cmp_arr;

  logic signed [VAL_W-1:0] vals [4];

  assign vals[0] = in_word.value_l0;
  assign vals[1] = in_word.value_l1;
  assign vals[2] = in_word.value_l2;
  assign vals[3] = in_word.value_l3;

  // ready chain: a stage moves when the next one is empty or moving
  assign rdy_b         = !v_c_r || rdy_c;
  assign rdy_a         = !v_b_r || rdy_b;
  assign in_word.ready = !v_a_r || rdy_a;

  assign accept  = in_word.valid && in_word.ready;
  assign cb_ok   = cb_in_range(in_word.codebook);
  assign acc_enc = accept && cb_ok && (func_e_t'(in_word.func) == FUNC_ENCODE);

  // table load broadcast; each lane picks its own level
  always_comb begin
    ld.wr    = accept && cb_ok && (func_e_t'(in_word.func) != FUNC_ENCODE);
    ld.func  = func_e_t'(in_word.func);
    ld.addr  = in_word.codebook[CB_AW-1:0];
    ld.level = in_word.level;
    ld.node  = in_word.node;
    ld.value = in_word.load_value;
  end

  assign en.rd  = acc_enc;
  assign en.mul = v_a_r && rdy_a;
  assign en.cmp = v_b_r && rdy_b;

  assign v_a_nxt = acc_enc || (v_a_r && !rdy_a);
  assign v_b_nxt = en.mul  || (v_b_r && !rdy_b);
  assign v_c_nxt = en.cmp  || (v_c_r && !rdy_c);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r <= 1'b0;
      v_b_r <= 1'b0;
      v_c_r <= 1'b0;
    end else begin
      v_a_r <= v_a_nxt;
      v_b_r <= v_b_nxt;
      v_c_r <= v_c_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en.rd) begin
      cb_a_r <= in_word.codebook;
    end
    if (en.mul) begin
      cb_b_r <= cb_a_r;
    end
    if (en.cmp) begin
      cb_c_r <= cb_b_r;
    end
  end

  // one lane per tree level, all levels of a row evaluated side by side
  for (genvar l = 0; l < TREE_DEPTH; l++) begin : g_lane
    mthe_lane u_lane (
      .clk     (clk),
      .lane_id (LEVEL_W'(l)),
      .ld      (ld),
      .en      (en),
      .rd_addr (in_word.codebook[CB_AW-1:0]),
      .x_in    (vals[l]),
      .cmp_o   (cmp_arr[l])
    );
  end

  // tree walk and output register
  mthe_merge u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmp_i    (cmp_arr),
    .v_i      (v_c_r),
    .cb_i     (cb_c_r),
    .rdy_o    (rdy_c),
    .out_word (out_word)
  );

endmodule

`default_nettype wire

// File: hw/rtl/mthe_lane.sv
// mthe_lane: one tree level; holds its tables, scales/offsets the value,
// rounds, saturates and compares against every node threshold of the level
// depends on mthe_pkg
`default_nettype none

module mthe_lane import mthe_pkg::*; (
  input  wire logic                    clk,
  input  wire logic [LEVEL_W-1:0]      lane_id,
  input  wire load_cmd_t               ld,
  input  wire stage_en_t               en,
  input  wire logic [CB_AW-1:0]        rd_addr,
  input  wire logic signed [VAL_W-1:0] x_in,
  output logic [NODES_PER_LEVEL-1:0]   cmp_o
);

  thr_row_t                thr_mem_r   [CB_SLOTS];
  logic signed [VAL_W-1:0] scale_mem_r [CB_SLOTS];
  logic signed [VAL_W-1:0] off_mem_r   [CB_SLOTS];

  thr_row_t                thr_a_r;
  thr_row_t                thr_b_r;
  logic signed [VAL_W-1:0] x_a_r;
  logic signed [VAL_W-1:0] s_a_r;
  logic signed [VAL_W-1:0] o_a_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] acc_nxt;
  logic signed [ACC_W-1:0] prod;
  logic [NODES_PER_LEVEL-1:0] cmp_r;
  logic [NODES_PER_LEVEL-1:0] cmp_nxt;

  logic signed [VAL_W-1:0] q;
  logic [VAL_W-1:0]        rem;
  logic                    inc;
  logic signed [VAL_W:0]   y;
  thr_t                    y_sat;

  // table writes and registered row read
  always_ff @(posedge clk) begin
    if (ld.wr && (ld.level == lane_id)) begin
      case (ld.func)
        FUNC_LOAD_THR:    thr_mem_r[ld.addr][ld.node] <= sat8({ld.value[VAL_W-1], ld.value});
        FUNC_LOAD_SCALE:  scale_mem_r[ld.addr] <= ld.value;
        FUNC_LOAD_OFFSET: off_mem_r[ld.addr]   <= ld.value;
        default: ;
      endcase
    end
    if (en.rd) begin
      thr_a_r <= thr_mem_r[rd_addr];
      s_a_r   <= scale_mem_r[rd_addr];
      o_a_r   <= off_mem_r[rd_addr];
      x_a_r   <= x_in;
    end
  end

  // x * s + o * 256, operands q8.8, sum q16.16
  assign prod    = x_a_r * s_a_r;
  assign acc_nxt = prod + $signed({{(ACC_W-VAL_W-8){o_a_r[VAL_W-1]}}, o_a_r, 8'd0});

  always_ff @(posedge clk) begin
    if (en.mul) begin
      acc_r   <= acc_nxt;
      thr_b_r <= thr_a_r;
    end
  end

  // round half to even, saturate, compare against all nodes
  always_comb begin
    q     = acc_r[ACC_W-1:VAL_W];
    rem   = acc_r[VAL_W-1:0];
    inc   = (rem > 16'h8000) || ((rem == 16'h8000) && q[0]);
    y     = $signed({q[VAL_W-1], q}) + $signed({{VAL_W{1'b0}}, inc});
    y_sat = sat8(y);
    for (int n = 0; n < NODES_PER_LEVEL; n++) begin
      cmp_nxt[n] = $signed(y_sat) > $signed(thr_b_r[n]);
    end
  end

  always_ff @(posedge clk) begin
    if (en.cmp) begin
      cmp_r <= cmp_nxt;
    end
  end

  assign cmp_o = cmp_r;

endmodule

`default_nettype wire

// File: hw/rtl/mthe_merge.sv
// mthe_merge: walks the tree over the per-level compare vectors and holds
// the result word for the output channel; depends on mthe_pkg and mthe_if
`default_nettype none

module mthe_merge import mthe_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire cmp_arr_t        cmp_i,
  input  wire logic            v_i,
  input  wire logic [CB_W-1:0] cb_i,
  output logic                 rdy_o,
  mthe_out_if.source           out_word
);

  logic                out_valid_r;
  logic                out_valid_nxt;
  logic [CB_W-1:0]     cb_r;
  logic [BUCKET_W-1:0] bucket_r;
  logic [BUCKET_W-1:0] bucket;

  // each level picks the bit of the node reached so far
  always_comb begin
    bucket = '0;
    for (int l = 0; l < TREE_DEPTH; l++) begin
      bucket = {bucket[BUCKET_W-2:0], cmp_i[l][bucket]};
    end
  end

  assign rdy_o         = !out_valid_r || out_word.ready;
  assign out_valid_nxt = (v_i && rdy_o) || (out_valid_r && !out_word.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (v_i && rdy_o) begin
      cb_r     <= cb_i;
      bucket_r <= bucket;
    end
  end

  assign out_word.valid         = out_valid_r;
  assign out_word.code_codebook = cb_r;
  assign out_word.bucket_code   = bucket_r;

endmodule

`default_nettype wire
